### rtl/core/sbfe_pkg.sv
// ----------------------------------------------------------------------------
// sbfe_pkg
// Shared types and constants of the six-bit frame encoder.
// ----------------------------------------------------------------------------
package sbfe_pkg;

  // Field widths of the channels and the configuration register.
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned HEADER_W = 6;

  // Default frame length in payload bytes (legal range 3..255).
  localparam int unsigned FRAME_BYTES_DEF = 36;

  // Framing and encoding constants.
  localparam logic [CHAR_W-1:0]   START_BYTE   = 8'h02;
  localparam logic [CHAR_W-1:0]   END_BYTE     = 8'h03;
  localparam logic [CHAR_W-1:0]   PRINT_BIT    = 8'h40;
  localparam logic [HEADER_W-1:0] HEADER_RESET = 6'h3F;

  // Most characters one payload byte can cause.
  localparam int unsigned MAX_RESULTS = 3;

  // One buffered result character.
  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              frame_end;
  } result_t;

endpackage

### rtl/core/sbfe_in_if.sv
// ----------------------------------------------------------------------------
// sbfe_in_if
// Input channel of the six-bit frame encoder: one payload byte per transfer.
// ----------------------------------------------------------------------------
interface sbfe_in_if;
  import sbfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);

endinterface

### rtl/core/sbfe_out_if.sv
// ----------------------------------------------------------------------------
// sbfe_out_if
// Result channel of the six-bit frame encoder: one character per transfer.
// ----------------------------------------------------------------------------
interface sbfe_out_if;
  import sbfe_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              frame_end;
  logic              last;

  modport source (output valid, output out_char, output frame_end, output last,
                  input ready);
  modport sink   (input valid, input out_char, input frame_end, input last,
                  output ready);

endinterface

### rtl/core/six_bit_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// six_bit_frame_encoder_top
// Radix-64 style encoder with start/end byte framing for a payload stream.
// ----------------------------------------------------------------------------
// Each accepted payload byte causes one to three result characters, which
// are computed in the cycle of the input transfer and held in a small result
// buffer that drives the output channel one character per cycle while the
// output is ready. A byte holds the block until its characters have transferred
// (one to three, about 1.4 on average over a frame); the next byte is taken
// in the same cycle as the final character of the previous one transfers, so
// with the output always ready there are no idle cycles between items. The
// first byte of a frame is preceded by the start byte and the header index,
// and the last byte is followed by the end byte, flagged with frame_end.
// The header index register may only be written while the block is idle.
module six_bit_frame_encoder_top #(
  parameter int unsigned FRAME_BYTES = sbfe_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sbfe_in_if.sink                       in_ch,
  sbfe_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [sbfe_pkg::HEADER_W-1:0] cfg_data
);
  import sbfe_pkg::*;

  localparam int unsigned POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  // Group phase codes.
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam int unsigned NCAND = 5;

  // Configuration and encoder state.
  logic [HEADER_W-1:0] header_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [3:0]          carry_r, carry_nxt;

  // Result buffer.
  result_t             slot_r [MAX_RESULTS];
  result_t             slot_nxt [MAX_RESULTS];
  logic [1:0]          num_r, num_nxt;
  logic [1:0]          rd_r;

  // Candidate characters for one byte, in output order.
  result_t             cand [NCAND];
  logic [NCAND-1:0]    cand_en;

  logic                in_xfer;
  logic                out_xfer;
  logic                buf_done;
  logic                frame_last;
  logic [DATA_W-1:0]   b;

  assign b        = in_ch.data_byte;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign buf_done = out_xfer && (rd_r == (num_r - 2'd1));
  assign in_ch.ready = (num_r == 2'd0) || buf_done;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign frame_last = (pos_r == POS_LAST);

  // Output channel driven straight from the buffer.
  assign out_ch.valid     = (num_r != 2'd0);
  assign out_ch.out_char  = slot_r[rd_r].out_char;
  assign out_ch.frame_end = slot_r[rd_r].frame_end;
  assign out_ch.last      = (rd_r == (num_r - 2'd1));

  // Encode one byte: candidate characters and the next encoder state.
  always_comb begin
    for (int i = 0; i < NCAND; i++) begin
      cand[i] = '{out_char: '0, frame_end: 1'b0};
    end
    cand_en   = '0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;

    // Start byte and header open a frame.
    cand[0].out_char = START_BYTE;
    cand[1].out_char = {2'b00, header_r};
    cand_en[0]       = (pos_r == '0);
    cand_en[1]       = (pos_r == '0);

    // Payload characters for the byte's place in its group.
    unique case (phase_r)
      PH_SECOND: begin
        cand[2].out_char = {carry_r, b[7:4]} | PRINT_BIT;
        cand_en[2]       = 1'b1;
        carry_nxt        = b[3:0];
        phase_nxt        = PH_THIRD;
      end
      PH_THIRD: begin
        cand[2].out_char = {2'b01, carry_r, b[7:6]};
        cand[3].out_char = {2'b01, b[5:0]};
        cand_en[2]       = 1'b1;
        cand_en[3]       = 1'b1;
        carry_nxt        = 4'd0;
        phase_nxt        = PH_FIRST;
      end
      default: begin
        cand[2].out_char = {2'b01, b[7:2]};
        cand_en[2]       = 1'b1;
        carry_nxt        = {2'b00, b[1:0]};
        phase_nxt        = PH_SECOND;
      end
    endcase

    // Closing the frame: flush leftover bits, then the end byte.
    if (frame_last) begin
      if (phase_nxt == PH_SECOND) begin
        cand[3].out_char = {2'b01, carry_nxt[1:0], 4'b0000};
        cand_en[3]       = 1'b1;
      end else if (phase_nxt == PH_THIRD) begin
        cand[3].out_char = {2'b01, carry_nxt, 2'b00};
        cand_en[3]       = 1'b1;
      end
      cand[4].out_char  = END_BYTE;
      cand[4].frame_end = 1'b1;
      cand_en[4]        = 1'b1;
      phase_nxt         = PH_FIRST;
      carry_nxt         = 4'd0;
    end

    pos_nxt = frame_last ? '0 : pos_r + POS_W'(1);
  end

  // Pack the enabled candidates into the buffer slots, keeping the first three.
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      slot_nxt[i] = cand[i];
    end
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && (n != 2'(MAX_RESULTS))) begin
        slot_nxt[n] = cand[i];
        n = n + 2'd1;
      end
    end
    num_nxt = n;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
    end else if (cfg_we) begin
      header_r <= cfg_data;
    end
  end

  // Encoder state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_FIRST;
      carry_r <= 4'd0;
    end else if (in_xfer) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  // Buffer control: load on input transfer, step on output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= 2'd0;
      rd_r  <= 2'd0;
    end else if (in_xfer) begin
      num_r <= num_nxt;
      rd_r  <= 2'd0;
    end else if (buf_done) begin
      num_r <= 2'd0;
      rd_r  <= 2'd0;
    end else if (out_xfer) begin
      rd_r  <= rd_r + 2'd1;
    end
  end

  // Buffer payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-bit frame encoder. A queue-fed driver
// sends payload bytes and a monitor predicts the framed character stream for
// every accepted byte. The monitor then checks each output transfer against
// the oldest predicted character. The header register is rewritten between
// phases while the block is idle. The phases vary the mix of sender gaps
// and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfe_pkg::*;

  localparam int unsigned FRAME_LEN      = FRAME_BYTES_DEF;
  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned BYTES_PER_PHASE = 21;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // One predicted character on the result channel.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              frame_end;
    logic              last;
  } enc_char_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [HEADER_W-1:0] cfg_data;

  sbfe_in_if  in_bus ();
  sbfe_out_if out_bus ();

  six_bit_frame_encoder_top #(
    .FRAME_BYTES (FRAME_LEN)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Bytes waiting to be sent and characters still owed by the block.
  logic [DATA_W-1:0] pending_bytes[$];
  enc_char_t         expected_chars[$];

  // Shadow copy of the encoder state and its header register.
  logic [HEADER_W-1:0] hdr_shadow;
  logic [7:0]          pos_q;
  logic [1:0]          phase_q;
  logic [3:0]          carry_q;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;

  // Clock generation.
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  function automatic enc_char_t make_char(input logic [CHAR_W-1:0] ch,
                                          input logic fe);
    enc_char_t c;
    c.ch        = ch;
    c.frame_end = fe;
    c.last      = 1'b0;
    return c;
  endfunction

  task automatic report_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Work out the characters that one payload byte causes and queue them.
  task automatic predict_chars(input logic [DATA_W-1:0] b);
    enc_char_t  produced[$];
    logic [3:0] c;
    c = carry_q;

    // A new frame opens with the start byte and the raw header index.
    if (pos_q == 8'd0) begin
      produced.push_back(make_char(START_BYTE, 1'b0));
      produced.push_back(make_char({2'b00, hdr_shadow}, 1'b0));
    end

    case (phase_q)
      2'd1: begin
        produced.push_back(make_char(8'({c, b[7:4]}) | PRINT_BIT, 1'b0));
        carry_q = b[3:0];
        phase_q = 2'd2;
      end
      2'd2: begin
        produced.push_back(make_char({2'b01, c, b[7:6]}, 1'b0));
        produced.push_back(make_char({2'b01, b[5:0]}, 1'b0));
        carry_q = 4'd0;
        phase_q = 2'd0;
      end
      default: begin
        produced.push_back(make_char({2'b01, b[7:2]}, 1'b0));
        carry_q = {2'b00, b[1:0]};
        phase_q = 2'd1;
      end
    endcase

    // The last byte of a frame flushes leftover bits and closes the frame.
    pos_q = pos_q + 8'd1;
    if (pos_q >= FRAME_LEN) begin
      c = carry_q;
      if (phase_q == 2'd1) begin
        produced.push_back(make_char({2'b01, c[1:0], 4'b0000}, 1'b0));
      end else if (phase_q == 2'd2) begin
        produced.push_back(make_char({2'b01, c, 2'b00}, 1'b0));
      end
      produced.push_back(make_char(END_BYTE, 1'b1));
      pos_q   = 8'd0;
      phase_q = 2'd0;
      carry_q = 4'd0;
    end

    // Only the first three characters survive; the final one carries last.
    while (produced.size() > MAX_RESULTS) begin
      void'(produced.pop_back());
    end
    produced[produced.size()-1].last = 1'b1;
    foreach (produced[i]) begin
      expected_chars.push_back(produced[i]);
    end
  endtask

  // Driver: presents queued bytes and randomizes the output ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid     <= 1'b1;
          in_bus.data_byte <= pending_bytes.pop_front();
        end else begin
          in_bus.valid     <= 1'b0;
          in_bus.data_byte <= DATA_W'($urandom);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on input transfers and checks output transfers.
  always @(posedge clk) begin : monitor_proc
    enc_char_t exp_c;
    if (!rst_n) begin
      hdr_shadow = HEADER_RESET;
      pos_q      = 8'd0;
      phase_q    = 2'd0;
      carry_q    = 4'd0;
      expected_chars.delete();
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_chars(in_bus.data_byte);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_chars.size() == 0) begin
          report_failure($sformatf("unexpected char %02h frame_end %0b last %0b",
                                   out_bus.out_char, out_bus.frame_end, out_bus.last));
        end else begin
          exp_c = expected_chars.pop_front();
          if (out_bus.out_char !== exp_c.ch || out_bus.frame_end !== exp_c.frame_end ||
              out_bus.last !== exp_c.last) begin
            report_failure($sformatf(
              "char exp %02h got %02h, frame_end exp %0b got %0b, last exp %0b got %0b",
              exp_c.ch, out_bus.out_char, exp_c.frame_end, out_bus.frame_end,
              exp_c.last, out_bus.last));
          end
        end
      end
      if (cfg_we) begin
        hdr_shadow = cfg_data;
      end
    end
  end

  // Hold the sender until every queued byte went out and every char came back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_bytes.size() != 0 || in_bus.valid || expected_chars.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_header(input logic [HEADER_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Stimulus: directed bytes first, then random phases with new headers.
  initial begin : stimulus
    logic [DATA_W-1:0] directed_bytes [24];
    int unsigned       send_plan      [PHASES];
    int unsigned       stall_plan     [PHASES];
    logic [HEADER_W-1:0] hdr_plan     [PHASES];

    directed_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                       8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                       8'h40, 8'h80, 8'hFE, 8'h55, 8'hAA, 8'h55,
                       8'hAA, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h3C};
    send_plan  = '{0, 69, 0, 9, 69, 0};
    stall_plan = '{0, 0, 69, 9, 0, 69};
    hdr_plan   = '{6'd0, 6'd63, 6'h2A, HEADER_W'($urandom), 6'h15,
                   HEADER_W'($urandom)};

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    out_bus.ready    = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    mismatch_count   = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bytes run under the reset header with no idling.
    foreach (directed_bytes[i]) begin
      pending_bytes.push_back(directed_bytes[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_header(hdr_plan[p]);
      send_idle_pct  = send_plan[p];
      recv_stall_pct = stall_plan[p];
      for (int k = 0; k < BYTES_PER_PHASE; k++) begin
        pending_bytes.push_back(DATA_W'($urandom));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_chars.size() != 0) begin
      report_failure($sformatf("%0d chars never arrived", expected_chars.size()));
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
